// File: hdl/jbmc_pkg.sv
// Shared types and constants for the baseline JPEG marker checker.
// No dependencies; imported by jbmc_step, jpeg_baseline_marker_checker_core and the testbench.
package jbmc_pkg;

  // Largest declared image size that is still parsed.
  localparam int unsigned MAX_IMAGE_BYTES = 32768;
  localparam logic [16:0] MAX_LEN         = 17'(MAX_IMAGE_BYTES);
  localparam logic [15:0] MIN_LEN         = 16'd4;
  // A marker must start at least this many bytes before the end.
  localparam logic [17:0] MARKER_GAP      = 18'd4;
  localparam logic [17:0] LEN_FIELD_ROOM  = 18'd3;
  localparam logic [15:0] MIN_SEG_LEN     = 16'd2;
  localparam logic [15:0] MIN_SOF0_LEN    = 16'd8;

  // Marker codes
  localparam logic [7:0] MK_FILL = 8'hff;
  localparam logic [7:0] MK_SOI  = 8'hd8;
  localparam logic [7:0] MK_EOI  = 8'hd9;
  localparam logic [7:0] MK_SOS  = 8'hda;
  localparam logic [7:0] MK_SOF0 = 8'hc0;
  localparam logic [7:0] MK_SOF1 = 8'hc1;
  localparam logic [7:0] MK_SOFF = 8'hcf;
  localparam logic [7:0] MK_DHT  = 8'hc4;
  localparam logic [7:0] MK_JPG  = 8'hc8;
  localparam logic [7:0] MK_DAC  = 8'hcc;

  localparam logic [7:0] PRECISION_8 = 8'h08;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_EXPECT_D8,
    PH_MARK_START,
    PH_FILL,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PRECISION,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] byte_position;
    logic [15:0] image_length;
    logic [7:0]  seg_len_hi;
    logic [16:0] segment_end;
    logic        frame_marker_seen;
  } jbmc_state_t;

  typedef struct packed {
    logic emit;
    logic ok;
  } jbmc_verdict_t;

endpackage

// File: hdl/jbmc_step.sv
// Parse step: next parser state and verdict for one image byte.
// Depends on jbmc_pkg.
module jbmc_step (
  input  jbmc_pkg::jbmc_state_t   st,
  input  logic                    start_req,
  input  logic [15:0]             total_length,
  input  logic [7:0]              data_byte,
  output jbmc_pkg::jbmc_state_t   st_nxt,
  output jbmc_pkg::jbmc_verdict_t verdict
);
  import jbmc_pkg::*;

  logic [17:0] pos18, len18, pos_p1, seg_end18;
  logic [15:0] seg16;
  logic        near_end_pos, near_end_old, near_end_new;
  logic        fill_at_end, no_room_len, seg_too_long, skip_done;
  logic        sof_bad, start_bad, seg_short, sof0_short, seg_empty;

  assign pos18     = {2'b00, st.byte_position};
  assign len18     = {2'b00, st.image_length};
  assign pos_p1    = pos18 + 18'd1;
  assign seg16     = {st.seg_len_hi, data_byte};
  // Segment length counts from the high length byte, one before the low length byte
  assign seg_end18 = pos18 - 18'd1 + {2'b00, seg16};

  assign near_end_pos = (pos_p1 + MARKER_GAP) > len18;
  assign near_end_old = ({1'b0, st.segment_end} + MARKER_GAP) > len18;
  assign near_end_new = (seg_end18 + MARKER_GAP) > len18;
  assign fill_at_end  = pos_p1 >= len18;
  assign no_room_len  = (pos18 + LEN_FIELD_ROOM) > len18;
  assign seg_too_long = seg_end18 > len18;
  assign skip_done    = pos_p1 >= {1'b0, st.segment_end};
  assign seg_short    = seg16 < MIN_SEG_LEN;
  assign sof0_short   = seg16 < MIN_SOF0_LEN;
  assign seg_empty    = seg16 == MIN_SEG_LEN;

  // SOF1..SOF15 reject, DHT/JPG/DAC share that range but are fine
  assign sof_bad = (data_byte >= MK_SOF1) && (data_byte <= MK_SOFF) &&
                   (data_byte != MK_DHT) && (data_byte != MK_JPG) &&
                   (data_byte != MK_DAC);

  assign start_bad = (total_length < MIN_LEN) || ({1'b0, total_length} > MAX_LEN) ||
                     (data_byte != MK_FILL);

  // Next state
  always_comb begin
    st_nxt = st;
    if (start_req) begin
      st_nxt.image_length      = total_length;
      st_nxt.byte_position     = 16'd1;
      st_nxt.seg_len_hi        = 8'd0;
      st_nxt.segment_end       = 17'd0;
      st_nxt.frame_marker_seen = 1'b0;
      st_nxt.phase             = start_bad ? PH_IDLE : PH_EXPECT_D8;
    end else if (st.phase != PH_IDLE) begin
      st_nxt.byte_position = pos_p1[15:0];
      unique case (st.phase)
        PH_IDLE: begin
          st_nxt.phase = PH_IDLE;
        end
        PH_EXPECT_D8: begin
          st_nxt.phase = ((data_byte != MK_SOI) || near_end_pos) ? PH_IDLE : PH_MARK_START;
        end
        PH_MARK_START: begin
          st_nxt.phase = (data_byte != MK_FILL) ? PH_IDLE : PH_FILL;
        end
        PH_FILL: begin
          priority if (data_byte == MK_FILL) begin
            if (fill_at_end) begin
              st_nxt.phase = PH_IDLE;
            end
          end else if (data_byte == MK_SOS) begin
            st_nxt.phase = PH_IDLE;
          end else if ((data_byte == MK_SOI) || (data_byte == MK_EOI)) begin
            st_nxt.phase = near_end_pos ? PH_IDLE : PH_MARK_START;
          end else if (sof_bad || no_room_len) begin
            st_nxt.phase = PH_IDLE;
          end else begin
            st_nxt.frame_marker_seen = (data_byte == MK_SOF0);
            st_nxt.phase             = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          st_nxt.seg_len_hi = data_byte;
          st_nxt.phase      = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_short || seg_too_long) begin
            st_nxt.phase = PH_IDLE;
          end else begin
            st_nxt.segment_end = seg_end18[16:0];
            priority if (st.frame_marker_seen) begin
              st_nxt.phase = sof0_short ? PH_IDLE : PH_PRECISION;
            end else if (seg_empty) begin
              st_nxt.phase = near_end_new ? PH_IDLE : PH_MARK_START;
            end else begin
              st_nxt.phase = PH_SKIP;
            end
          end
        end
        PH_PRECISION: begin
          st_nxt.phase = PH_IDLE;
        end
        PH_SKIP: begin
          if (skip_done) begin
            st_nxt.phase = near_end_old ? PH_IDLE : PH_MARK_START;
          end
        end
        default: begin
          st_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

  // Outputs: a verdict is due whenever a live parse drops back to idle
  always_comb begin
    verdict.emit = (start_req || (st.phase != PH_IDLE)) && (st_nxt.phase == PH_IDLE);
    verdict.ok   = !start_req && (st.phase == PH_PRECISION) && (data_byte == PRECISION_8);
  end

endmodule

// File: hdl/jpeg_baseline_marker_checker_core.sv
// Baseline JPEG marker checker, top level: input register, parse step, verdict register.
// Depends on jbmc_pkg and jbmc_step.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid, in_stall, in_start_req, in_total_length, | into core
//          | in_data_byte                                       |
//  out     | out_valid, out_stall, out_baseline_ok              | out of core
//
// One byte per cycle sustained while a stalled verdict does not hold the parse step.
// A byte is held in the input register; the parse step then updates the state and,
// when the image is settled, loads the verdict register, which drives out_valid.
// rst_n (synchronous, active low) idles the parser and empties both registers.
// A stalled verdict in the output register freezes the parse step for any byte;
// one more byte is still taken into the input register if that was empty.
module jpeg_baseline_marker_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_req,
  input  logic [15:0] in_total_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_baseline_ok
);
  import jbmc_pkg::*;

  // Input register
  logic        in_vld_r;
  logic        in_start_r;
  logic [15:0] in_len_r;
  logic [7:0]  in_byte_r;

  // Parser state and verdict register
  jbmc_state_t   st_r, st_nxt;
  jbmc_verdict_t verdict;
  logic          out_vld_r, out_vld_nxt;
  logic          out_ok_r;
  logic          adv;

  jbmc_step u_step (
    .st           (st_r),
    .start_req    (in_start_r),
    .total_length (in_len_r),
    .data_byte    (in_byte_r),
    .st_nxt       (st_nxt),
    .verdict      (verdict)
  );

  // The registered byte moves on when the verdict register is free or draining.
  assign adv         = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = in_vld_r && !adv;
  assign out_vld_nxt = (adv && verdict.emit) || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_start_r <= in_start_req;
      in_len_r   <= in_total_length;
      in_byte_r  <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase             <= PH_IDLE;
      st_r.byte_position     <= 16'd0;
      st_r.image_length      <= 16'd0;
      st_r.seg_len_hi        <= 8'd0;
      st_r.segment_end       <= 17'd0;
      st_r.frame_marker_seen <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && verdict.emit) begin
      out_ok_r <= verdict.ok;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_baseline_ok = out_ok_r;

`ifndef SYNTHESIS
  // A verdict always leaves the parser idle and lands in the output register.
  a_verdict_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && verdict.emit) |=> (st_r.phase == PH_IDLE) && out_vld_r)
    else $error("verdict did not idle the parser or load the output");

  // A passing verdict only comes from the precision byte of SOF0.
  a_pass_source: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && verdict.emit && verdict.ok) |-> (st_r.phase == PH_PRECISION) && !in_start_r)
    else $error("pass verdict outside precision check");

  // A live parse never runs past the declared image length.
  a_within_image: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase != PH_IDLE) |-> (st_r.byte_position <= st_r.image_length))
    else $error("parse ran past image end");
`endif

endmodule

// File: verif/jpeg_baseline_marker_checker_core_test.sv
// Self-checking testbench for jpeg_baseline_marker_checker_core: byte streams in, verdicts out.
// Depends on jbmc_pkg and the core RTL; an in-file marker-walk predictor supplies the verdicts.
module jpeg_baseline_marker_checker_core_test;
  import jbmc_pkg::*;

  // Marker codes used only to build legal filler segments
  localparam logic [7:0] MK_DQT  = 8'hdb;
  localparam logic [7:0] MK_APP0 = 8'he0;
  localparam logic [7:0] MK_COM  = 8'hfe;

  localparam int unsigned LIVE_GOAL   = 850;
  localparam int unsigned IMAGE_GOAL  = 40;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned TAIL_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_start_req;
  logic [15:0] in_total_length;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_baseline_ok;

  jpeg_baseline_marker_checker_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_req    (in_start_req),
    .in_total_length (in_total_length),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_baseline_ok (out_baseline_ok)
  );

  // Parser shadow state
  phase_t      ph;
  logic [15:0] pos_cnt;
  logic [15:0] img_len;
  logic [15:0] seg_len;
  logic [16:0] seg_end;
  logic        sof0_seg;

  bit          verdict_q[$];
  logic [7:0]  img_bytes[$];

  int unsigned fail_cnt;
  int unsigned live_items;
  int unsigned verdicts_checked;
  int unsigned accepts_seen;
  int unsigned images_sent;
  int unsigned input_held;
  int unsigned hold_req;
  bit          tx_calm;
  bit          rx_calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("jpeg_baseline_marker_checker_core verification failed");
    $finish;
  end

  // Wait count for one item on either side; calm means back-to-back
  function automatic int unsigned idle_draw(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Next byte at q must open a marker; returns 1 when that cannot fit
  function automatic bit open_marker(int unsigned q);
    if (q + MARKER_GAP > img_len) return 1'b1;
    ph = PH_MARK_START;
    return 1'b0;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a verdict is due
  function automatic bit parse_byte(bit start, logic [15:0] len, logic [7:0] b, output bit ok);
    int unsigned p;
    int unsigned s;
    bit          done;
    ok   = 1'b0;
    done = 1'b0;
    if (start) begin
      img_len  = len;
      pos_cnt  = 16'd1;
      seg_len  = '0;
      seg_end  = '0;
      sof0_seg = 1'b0;
      ph       = PH_EXPECT_D8;
      if (len < MIN_LEN || len > MAX_IMAGE_BYTES || b != MK_FILL) done = 1'b1;
    end else if (ph != PH_IDLE) begin
      p       = pos_cnt;
      pos_cnt = pos_cnt + 16'd1;
      case (ph)
        PH_EXPECT_D8: begin
          if (b != MK_SOI) done = 1'b1;
          else done = open_marker(p + 1);
        end
        PH_MARK_START: begin
          if (b != MK_FILL) done = 1'b1;
          else ph = PH_FILL;
        end
        PH_FILL: begin
          if (b == MK_FILL) begin
            // fill run may not run into the end of the image
            if (p + 1 >= img_len) done = 1'b1;
          end else if (b == MK_SOS) begin
            done = 1'b1;
          end else if (b == MK_SOI || b == MK_EOI) begin
            done = open_marker(p + 1);
          end else if (b >= MK_SOF1 && b <= MK_SOFF && b != MK_DHT && b != MK_JPG &&
                       b != MK_DAC) begin
            done = 1'b1;
          end else if (p + LEN_FIELD_ROOM > img_len) begin
            done = 1'b1;
          end else begin
            sof0_seg = (b == MK_SOF0);
            ph       = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          seg_len = {b, 8'h00};
          ph      = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          s       = {seg_len[15:8], b};
          seg_len = s[15:0];
          if (s < MIN_SEG_LEN || (p - 1) + s > img_len) begin
            done = 1'b1;
          end else begin
            seg_end = 17'((p - 1) + s);
            if (sof0_seg) begin
              if (s < MIN_SOF0_LEN) done = 1'b1;
              else ph = PH_PRECISION;
            end else if (s == MIN_SEG_LEN) begin
              done = open_marker(seg_end);
            end else begin
              ph = PH_SKIP;
            end
          end
        end
        PH_PRECISION: begin
          done = 1'b1;
          ok   = (b == PRECISION_8);
        end
        PH_SKIP: begin
          if (p + 1 >= seg_end) done = open_marker(seg_end);
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (done) ph = PH_IDLE;
    return done;
  endfunction

  // Offers one byte at the falling edge and holds it until taken
  task automatic push_byte(bit start, logic [15:0] len, logic [7:0] b);
    int unsigned gap;
    bit          ok;
    gap = idle_draw(tx_calm);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_start_req    = start;
    in_total_length = len;
    in_data_byte    = b;
    do @(posedge clk); while (in_stall);
    if (start || ph != PH_IDLE) live_items++;
    if (parse_byte(start, len, b, ok)) verdict_q = {verdict_q, ok};
  endtask

  // Sends the first count bytes of img_bytes as one image; may stop once settled
  task automatic send_image(logic [15:0] total, int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      push_byte(k == 0, (k == 0) ? total : 16'($urandom), img_bytes[k]);
      if (ph == PH_IDLE && $urandom_range(0, 3) != 0) break;
    end
    images_sent++;
  endtask

  // Random image: SOI, a few legal segments, then an SOF0 frame, optionally damaged
  task automatic build_image(output logic [15:0] total);
    int unsigned seglen;
    int unsigned sof_at;
    logic [7:0]  code;
    img_bytes = {MK_FILL, MK_SOI};
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 3)) img_bytes = {img_bytes, MK_FILL};
      case ($urandom_range(0, 5))
        0: code = $urandom_range(0, 1) ? MK_SOI : MK_EOI;
        1: code = MK_DHT;
        2: code = $urandom_range(0, 1) ? MK_JPG : MK_DAC;
        3: code = MK_DQT;
        4: code = MK_APP0 + 8'($urandom_range(0, 15));
        default: begin
          code = 8'($urandom);
          if ((code >= MK_SOF0 && code <= MK_SOFF) || code == MK_SOS || code == MK_FILL)
            code = MK_COM;
        end
      endcase
      img_bytes = {img_bytes, code};
      if (code != MK_SOI && code != MK_EOI) begin
        seglen = $urandom_range(2, 9);
        img_bytes = {img_bytes, 8'(seglen >> 8)};
        img_bytes = {img_bytes, 8'(seglen)};
        repeat (seglen - 2) img_bytes = {img_bytes, 8'($urandom)};
      end
    end
    repeat ($urandom_range(1, 2)) img_bytes = {img_bytes, MK_FILL};
    sof_at = img_bytes.size();
    seglen = $urandom_range(8, 13);
    img_bytes = {img_bytes, MK_SOF0};
    img_bytes = {img_bytes, 8'(seglen >> 8)};
    img_bytes = {img_bytes, 8'(seglen)};
    img_bytes = {img_bytes, (($urandom_range(0, 7) != 0) ? PRECISION_8 : 8'($urandom))};
    repeat (seglen - 3) img_bytes = {img_bytes, 8'($urandom)};
    total = 16'(img_bytes.size() + $urandom_range(0, 6));
    case ($urandom_range(0, 7))
      0: img_bytes[$urandom_range(1, img_bytes.size() - 1)] = 8'($urandom);
      1: total = 16'($urandom_range(MIN_LEN, img_bytes.size()));
      2: total = 16'($urandom);
      3: img_bytes[sof_at] = ($urandom_range(0, 4) == 0) ? MK_SOS :
                             8'($urandom_range(MK_SOF0, MK_SOFF));
      4: img_bytes[sof_at + 2] = 8'($urandom_range(0, 7));
      default: ;
    endcase
  endtask

  // Short, oversize and malformed starts, plus a byte with no image open
  task automatic test_length_limits;
    img_bytes = {MK_FILL};
    send_image(16'd3, 1);
    send_image(16'(MAX_IMAGE_BYTES + 1), 1);
    push_byte(1'b0, 16'hffff, 8'h00);
    img_bytes = {8'h00};
    send_image(16'hffff, 1);
  endtask

  // Restart in the middle of an image, then a minimal accepted frame behind fill
  task automatic test_restart_accept;
    img_bytes = {MK_FILL, MK_SOI};
    send_image(16'd16, 2);
    img_bytes = {MK_FILL, MK_SOI, MK_FILL, MK_FILL, MK_SOF0, 8'h00, 8'h08, PRECISION_8};
    send_image(16'd16, img_bytes.size());
  endtask

  // Fill reaching the end, marker too close to the end, forbidden SOF, scan start
  task automatic test_marker_rejects;
    img_bytes = {MK_FILL, MK_SOI, MK_FILL, MK_FILL, MK_FILL, MK_FILL};
    send_image(16'd6, img_bytes.size());
    img_bytes = {MK_FILL, MK_SOI};
    send_image(16'd5, img_bytes.size());
    img_bytes = {MK_FILL, MK_SOI, MK_FILL, MK_SOF1};
    send_image(16'(MAX_IMAGE_BYTES), img_bytes.size());
    img_bytes = {MK_FILL, MK_SOI, MK_FILL, MK_SOS};
    send_image(16'd8, img_bytes.size());
  endtask

  // Receiver stops for a long stretch while short images keep coming back to back
  task automatic test_backpressure;
    tx_calm  = 1'b1;
    hold_req = HOLD_CYCLES;
    repeat (24) begin
      img_bytes = {8'($urandom)};
      send_image(16'($urandom_range(0, 3)), 1);
    end
    tx_calm = 1'b0;
  endtask

  task automatic test_random_images;
    logic [15:0] total;
    int unsigned count;
    while (live_items < LIVE_GOAL || images_sent < IMAGE_GOAL) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      rx_calm = ($urandom_range(0, 5) == 0);
      build_image(total);
      // now and then cut the image short so the next start lands mid-parse
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, img_bytes.size() - 1) :
              img_bytes.size();
      send_image(total, count);
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) push_byte(1'b0, 16'($urandom), 8'($urandom));
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Result side: random stall per verdict, plus one long counted hold on request
  initial begin : verdict_sink
    int unsigned wait_n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req != 0) begin
        wait_n   = hold_req;
        hold_req = 0;
      end else begin
        wait_n = idle_draw(rx_calm);
      end
      repeat (wait_n) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares each taken verdict with the oldest prediction
  always @(posedge clk) begin : verdict_check
    bit want;
    if (rst_n && in_valid && in_stall) input_held++;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("baseline_ok: expected none, actual %0b", out_baseline_ok);
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        verdicts_checked++;
        if (want) accepts_seen++;
        if (out_baseline_ok !== want) begin
          $error("baseline_ok: expected %0b, actual %0b", want, out_baseline_ok);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_start_req    = 1'b0;
    in_total_length = '0;
    in_data_byte    = '0;
    ph              = PH_IDLE;
    pos_cnt         = '0;
    img_len         = '0;
    seg_len         = '0;
    seg_end         = '0;
    sof0_seg        = 1'b0;
    fail_cnt        = 0;
    live_items      = 0;
    verdicts_checked = 0;
    accepts_seen    = 0;
    images_sent     = 0;
    input_held      = 0;
    hold_req        = 0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_length_limits();
    test_restart_accept();
    test_marker_rejects();
    test_backpressure();
    test_random_images();

    @(negedge clk);
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d parsed bytes over %0d images; %0d verdicts checked, %0d accepts.",
             live_items, images_sent, verdicts_checked, accepts_seen);
    $display("Input side was held off for %0d cycles by result back-pressure.", input_held);
    if (fail_cnt == 0 && verdict_q.size() == 0) begin
      $display("jpeg_baseline_marker_checker_core verification clean");
    end else begin
      $display("jpeg_baseline_marker_checker_core verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/jbmc_pkg.sv
hdl/jbmc_step.sv
hdl/jpeg_baseline_marker_checker_core.sv
verif/jpeg_baseline_marker_checker_core_test.sv
